// ----- sv/tdad_pkg.sv -----
// tdad_pkg: shared sizes, command/result codes and chain control types
// for the tick-divided activity dispatcher. No dependencies.
package tdad_pkg;

   localparam int MaxSlots = 32;
   localparam int IdW      = 8;
   localparam int IdPortW  = 8;
   localparam int CmdW     = 3;
   localparam int KindW    = 3;
   localparam int DivW     = 16;
   localparam int SlotIdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
   localparam int FillW    = $clog2(MaxSlots + 1);

   // commands
   localparam logic [CmdW-1:0] CMD_TICK   = 3'd0;
   localparam logic [CmdW-1:0] CMD_ADD    = 3'd1;
   localparam logic [CmdW-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CmdW-1:0] CMD_START  = 3'd3;
   localparam logic [CmdW-1:0] CMD_STOP   = 3'd4;

   // result kinds
   localparam logic [KindW-1:0] KIND_ADD    = 3'd0;
   localparam logic [KindW-1:0] KIND_REMOVE = 3'd1;
   localparam logic [KindW-1:0] KIND_STEP   = 3'd2;
   localparam logic [KindW-1:0] KIND_STOP   = 3'd3;
   localparam logic [KindW-1:0] KIND_DONE   = 3'd4;

   // chain operations
   localparam logic [2:0] CHAIN_HOLD    = 3'd0;
   localparam logic [2:0] CHAIN_ROTATE  = 3'd1;
   localparam logic [2:0] CHAIN_COMPACT = 3'd2;
   localparam logic [2:0] CHAIN_WRITE   = 3'd3;
   localparam logic [2:0] CHAIN_REMOVE  = 3'd4;

   typedef struct packed {
      logic [2:0]          op;
      logic                kill;      // rotate: head re-enters tail invalid
      logic [IdW-1:0]      id;        // write / remove key
      logic [SlotIdxW-1:0] wr_index;  // write target slot
   } chain_ctl_type;

   typedef struct packed {
      logic [IdW-1:0] head_id;
      logic           head_valid;
      logic           remove_hit;     // some slot matched the remove key
      logic           compact_need;   // a hole sits ahead of a live slot
   } chain_status_type;

endpackage

// ----- sv/tdad_cell.sv -----
// tdad_cell: one list slot (ID plus valid bit) with neighbor links.
// Depends on tdad_pkg.
module tdad_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  tdad_pkg::chain_ctl_type         ctl,
   input  logic [tdad_pkg::SlotIdxW-1:0]   index,
   input  logic [tdad_pkg::IdW-1:0]        nbr_id,
   input  logic                            nbr_valid,
   input  logic                            hole_in,
   output logic                            hole_out,
   input  logic                            found_in,
   output logic                            found_out,
   output logic [tdad_pkg::IdW-1:0]        id_out,
   output logic                            valid_out,
   output logic                            need_out
);

   logic [tdad_pkg::IdW-1:0] id_ff, id_in;
   logic                     valid_ff, valid_in;
   logic                     match;
   logic                     hit;

   assign match     = valid_ff && (id_ff == ctl.id);
   assign hit       = match && !found_in;
   assign found_out = found_in || match;
   assign hole_out  = hole_in || !valid_ff;
   assign need_out  = hole_in && valid_ff;
   assign id_out    = id_ff;
   assign valid_out = valid_ff;

   always_comb begin
      id_in    = id_ff;
      valid_in = valid_ff;
      case (ctl.op)
         tdad_pkg::CHAIN_ROTATE: begin
            id_in    = nbr_id;
            valid_in = nbr_valid;
         end
         tdad_pkg::CHAIN_COMPACT: begin
            // everything from the first hole onward slides down one place
            if (hole_out) begin
               id_in    = nbr_id;
               valid_in = nbr_valid;
            end
         end
         tdad_pkg::CHAIN_WRITE: begin
            if (index == ctl.wr_index) begin
               id_in    = ctl.id;
               valid_in = 1'b1;
            end
         end
         tdad_pkg::CHAIN_REMOVE: begin
            if (hit) begin
               valid_in = 1'b0;
            end
         end
         default: begin
            id_in    = id_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

endmodule

// ----- sv/tdad_chain.sv -----
// tdad_chain: the row of slot cells, neighbor wiring and status collection.
// Depends on tdad_pkg and tdad_cell.
module tdad_chain (
   input  logic                         clock,
   input  logic                         reset,
   input  tdad_pkg::chain_ctl_type      ctl,
   output tdad_pkg::chain_status_type   status
);

   localparam int N = tdad_pkg::MaxSlots;

   logic [tdad_pkg::IdW-1:0] cell_id   [N];
   logic                     cell_valid[N];
   logic [tdad_pkg::IdW-1:0] nbr_id    [N];
   logic                     nbr_valid [N];
   logic [N:0]               hole;
   logic [N:0]               found;
   logic [N-1:0]             need;

   assign hole[0]  = 1'b0;
   assign found[0] = 1'b0;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         if (g == N - 1) begin : g_tail
            // tail refills from the head on rotate unless kill is set, with an empty slot otherwise
            assign nbr_id[g]    = cell_id[0];
            assign nbr_valid[g] = (ctl.op == tdad_pkg::CHAIN_ROTATE) &&
                                  cell_valid[0] && !ctl.kill;
         end else begin : g_body
            assign nbr_id[g]    = cell_id[g+1];
            assign nbr_valid[g] = cell_valid[g+1];
         end

         tdad_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .index     (tdad_pkg::SlotIdxW'(g)),
            .nbr_id    (nbr_id[g]),
            .nbr_valid (nbr_valid[g]),
            .hole_in   (hole[g]),
            .hole_out  (hole[g+1]),
            .found_in  (found[g]),
            .found_out (found[g+1]),
            .id_out    (cell_id[g]),
            .valid_out (cell_valid[g]),
            .need_out  (need[g])
         );
      end
   endgenerate

   assign status.head_id      = cell_id[0];
   assign status.head_valid   = cell_valid[0];
   assign status.remove_hit   = found[N];
   assign status.compact_need = |need;

endmodule

// ----- sv/tick_divided_activity_dispatcher.sv -----
// tick_divided_activity_dispatcher: top level, command sequencer around the
// slot chain. Depends on tdad_pkg and tdad_chain.
//
//  channel | ports                                      | flow control
//  --------+--------------------------------------------+------------------------
//  command | start, busy, req_cmd, req_activity_id      | transfer when start & !busy
//  result  | rsp_strobe, rsp_kind, rsp_ok,              | one cycle per strobe,
//          | rsp_target_id, rsp_last                    | no backpressure
//  config  | csr_valid, csr_ready, csr_tick_divide      | transfer when valid & ready
//
// Add, remove, start and unused codes keep busy low; a new command may
// follow in the next cycle. A dispatching tick or a stop rotates the whole
// slot chain once and then gives the final result; a tick with cleanup
// pending then slides out holes, one per cycle, and then finishes.
// Synchronous active-high reset empties the list, sets the turn to 1 and the
// divide ratio to 1. Results are never stalled; busy is the only throttle.
module tick_divided_activity_dispatcher (
   input  logic                             clock,
   input  logic                             reset,
   // command
   input  logic                             start,
   output logic                             busy,
   input  logic [tdad_pkg::CmdW-1:0]        req_cmd,
   input  logic [tdad_pkg::IdPortW-1:0]     req_activity_id,
   // results
   output logic                             rsp_strobe,
   output logic [tdad_pkg::KindW-1:0]       rsp_kind,
   output logic                             rsp_ok,
   output logic [tdad_pkg::IdPortW-1:0]     rsp_target_id,
   output logic                             rsp_last,
   // config
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tdad_pkg::DivW-1:0]        csr_tick_divide
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SCAN    = 2'd1;   // rotating, emitting live slots
   localparam logic [1:0] ST_FINISH  = 2'd2;   // final (last) result
   localparam logic [1:0] ST_COMPACT = 2'd3;   // removing holes

   localparam int FillW = tdad_pkg::FillW;
   localparam int IdxW  = tdad_pkg::SlotIdxW;
   localparam int DivW  = tdad_pkg::DivW;

   logic [1:0]                  state_ff, state_in;
   logic [IdxW-1:0]             cnt_ff, cnt_in;
   logic                        stop_ff, stop_in;        // scan belongs to stop
   logic                        held_vld_ff, held_vld_in;
   logic [tdad_pkg::IdW-1:0]    held_id_ff, held_id_in;  // result delayed one slot
   logic [FillW-1:0]            fill_ff, fill_in;        // slots in use, holes too
   logic [FillW-1:0]            live_ff, live_in;        // valid slots only
   logic [DivW-1:0]             turn_ff, turn_in;
   logic                        cleanup_ff, cleanup_in;
   logic [DivW-1:0]             divide_ff;

   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [tdad_pkg::KindW-1:0]  rsp_kind_ff, rsp_kind_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic [tdad_pkg::IdPortW-1:0] rsp_id_ff, rsp_id_in;
   logic                        rsp_last_ff, rsp_last_in;

   tdad_pkg::chain_ctl_type     ctl;
   tdad_pkg::chain_status_type  status;

   logic                        accept;
   logic [tdad_pkg::IdW-1:0]    key;
   logic [DivW-1:0]             ratio;
   logic [tdad_pkg::KindW-1:0]  held_kind;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign key       = req_activity_id[tdad_pkg::IdW-1:0];
   assign ratio     = (divide_ff == '0) ? DivW'(1) : divide_ff;
   assign held_kind = stop_ff ? tdad_pkg::KIND_STOP : tdad_pkg::KIND_STEP;

   tdad_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .status (status)
   );

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      stop_in     = stop_ff;
      held_vld_in = held_vld_ff;
      held_id_in  = held_id_ff;
      fill_in     = fill_ff;
      live_in     = live_ff;
      turn_in     = turn_ff;
      cleanup_in  = cleanup_ff;

      rsp_strobe_in = 1'b0;
      rsp_kind_in   = tdad_pkg::KIND_DONE;
      rsp_ok_in     = 1'b1;
      rsp_id_in     = '0;
      rsp_last_in   = 1'b1;

      ctl.op       = tdad_pkg::CHAIN_HOLD;
      ctl.kill     = stop_ff;
      ctl.id       = key;
      ctl.wr_index = fill_ff[IdxW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  tdad_pkg::CMD_TICK: begin
                     stop_in     = 1'b0;
                     held_vld_in = 1'b0;
                     cnt_in      = '0;
                     // dispatch on turn 1, then advance turn modulo the ratio
                     state_in    = (turn_ff == DivW'(1)) ? ST_SCAN : ST_FINISH;
                     turn_in     = (turn_ff >= ratio) ? DivW'(1) : turn_ff + DivW'(1);
                  end
                  tdad_pkg::CMD_ADD: begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = tdad_pkg::KIND_ADD;
                     rsp_id_in     = tdad_pkg::IdPortW'(key);
                     if (fill_ff < FillW'(tdad_pkg::MaxSlots)) begin
                        ctl.op  = tdad_pkg::CHAIN_WRITE;
                        fill_in = fill_ff + FillW'(1);
                        live_in = live_ff + FillW'(1);
                     end else begin
                        rsp_ok_in = 1'b0;
                     end
                  end
                  tdad_pkg::CMD_REMOVE: begin
                     ctl.op        = tdad_pkg::CHAIN_REMOVE;
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = tdad_pkg::KIND_REMOVE;
                     rsp_id_in     = tdad_pkg::IdPortW'(key);
                     rsp_ok_in     = status.remove_hit;
                     if (status.remove_hit) begin
                        live_in    = live_ff - FillW'(1);
                        cleanup_in = 1'b1;
                     end
                  end
                  tdad_pkg::CMD_START: begin
                     turn_in       = DivW'(1);
                     rsp_strobe_in = 1'b1;
                  end
                  tdad_pkg::CMD_STOP: begin
                     stop_in     = 1'b1;
                     held_vld_in = 1'b0;
                     cnt_in      = '0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // head slot leaves at cell 0 and re-enters at the tail
            ctl.op = tdad_pkg::CHAIN_ROTATE;
            if (status.head_valid) begin
               if (held_vld_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_kind_in   = held_kind;
                  rsp_id_in     = tdad_pkg::IdPortW'(held_id_ff);
                  rsp_last_in   = 1'b0;
               end
               held_vld_in = 1'b1;
               held_id_in  = status.head_id;
            end
            cnt_in = cnt_ff + IdxW'(1);
            if (cnt_ff == IdxW'(tdad_pkg::MaxSlots - 1)) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            if (held_vld_ff) begin
               rsp_kind_in = held_kind;
               rsp_id_in   = tdad_pkg::IdPortW'(held_id_ff);
            end
            held_vld_in = 1'b0;
            if (stop_ff) begin
               // every slot was invalidated, so the list is simply empty
               fill_in    = '0;
               live_in    = '0;
               cleanup_in = 1'b0;
               state_in   = ST_IDLE;
            end else if (cleanup_ff) begin
               state_in = ST_COMPACT;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_COMPACT: begin
            if (status.compact_need) begin
               ctl.op = tdad_pkg::CHAIN_COMPACT;
            end else begin
               fill_in    = live_ff;
               cleanup_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         stop_ff       <= 1'b0;
         held_vld_ff   <= 1'b0;
         fill_ff       <= '0;
         live_ff       <= '0;
         turn_ff       <= DivW'(1);
         cleanup_ff    <= 1'b0;
         divide_ff     <= DivW'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         stop_ff       <= stop_in;
         held_vld_ff   <= held_vld_in;
         fill_ff       <= fill_in;
         live_ff       <= live_in;
         turn_ff       <= turn_in;
         cleanup_ff    <= cleanup_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            divide_ff <= csr_tick_divide;
         end
      end
   end

   // result payload, meaningful only with the strobe
   always_ff @(posedge clock) begin
      held_id_ff  <= held_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_target_id = rsp_id_ff;
   assign rsp_last      = rsp_last_ff;

   // live slots never outnumber the slots in use
   assert property (@(posedge clock) disable iff (reset) live_ff <= fill_ff)
      else $error("live count exceeds fill count");

   // the turn counter never reaches zero
   assert property (@(posedge clock) disable iff (reset) turn_ff != '0)
      else $error("turn counter is zero");

   // every multi-cycle command closes with a last-marked result
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |=> rsp_strobe && rsp_last)
      else $error("finish cycle produced no final result");

   // fill count stays within capacity
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillW'(tdad_pkg::MaxSlots))
      else $error("fill count beyond capacity");

endmodule
